// ===== rtl/bba_pkg.sv =====
package bba_pkg;

  // pool geometry
  localparam int NUM_BLOCKS  = 1024;
  localparam int BLOCK_BYTES = 64;
  localparam int BLK_W       = $clog2(NUM_BLOCKS);
  localparam int CNT_W       = BLK_W + 1;
  localparam int BB_SH       = $clog2(BLOCK_BYTES);

  // request fields
  localparam int BYTES_W = 20;
  localparam int OVH_W   = 8;
  localparam logic [OVH_W-1:0] OVH_RESET = 8'd40;
  localparam int SUM_W   = BYTES_W + 1;
  localparam int NEED_W  = SUM_W - BB_SH;

  // free map is held as chunks of CHUNK_W blocks, one chunk per RAM word
  localparam int CHUNK_W    = 8;
  localparam int CHUNK_SH   = $clog2(CHUNK_W);
  localparam int NUM_CHUNKS = NUM_BLOCKS / CHUNK_W;
  localparam int CHUNK_AW   = $clog2(NUM_CHUNKS);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ZERO    = 2'd1,
    ST_NOSPACE = 2'd2,
    ST_BADFREE = 2'd3
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_FCHK,
    S_SCAN,
    S_MARK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    clr_step;
    logic    load;
    logic    scan_start;
    logic    scan_step;
    logic    mark_begin;
    logic    mark_step;
    logic    res_load;
    status_t res_code;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_free;
    logic zero_size;
    logic need_ok;
    logic free_ok;
    logic scan_hit;
    logic scan_end;
    logic mark_done;
  } dp_stat_t;

endpackage

// ===== rtl/bba_if.sv =====
interface bba_req_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [bba_pkg::BYTES_W-1:0]  alloc_bytes;
  logic [bba_pkg::BLK_W-1:0]    free_start;

  modport source (output valid, cmd, alloc_bytes, free_start, input ready);
  modport sink   (input valid, cmd, alloc_bytes, free_start, output ready);
endinterface

interface bba_rsp_if;
  logic                       valid;
  logic                       ready;
  bba_pkg::status_t           status;
  logic [bba_pkg::BLK_W-1:0]  start_block;
  logic [bba_pkg::CNT_W-1:0]  run_blocks;
  logic [bba_pkg::CNT_W-1:0]  free_blocks_left;

  modport source (output valid, status, start_block, run_blocks, free_blocks_left,
                  input ready);
  modport sink   (input valid, status, start_block, run_blocks, free_blocks_left,
                  output ready);
endinterface

// ===== rtl/bitmap_block_allocator_unit.sv =====
// Bitmap first-fit allocator over a pool of 1024 blocks of 64 bytes.
// req carries one word per request: cmd (0 allocate, 1 free), alloc_bytes
// and free_start. rsp returns one word per request: status, start_block,
// run_blocks and free_blocks_left. header_overhead is written through
// cfg_wr_en / cfg_wr_data; the user must write it only while no request
// is in flight, as the block itself does not enforce this.
// An allocate that fails on size or free count goes straight to its
// result; a granted allocate scans the free map from chunk 0 until a run
// fits, then rewrites each chunk that the run spans; a free reads its run
// record, checks it and rewrites the chunks of the run. The chunk scan and
// the chunk rewrite share the single read port of the free-map RAM, one
// chunk per cycle. The next request is taken in the cycle after the result
// is loaded, whether or not rsp has been drained.
// Reset: a clearing pass over every block marks every block free and drops
// every run record; req.ready stays low until it ends.
// Stall: a result waits in the output register while rsp.ready is low; a
// following request is worked on and holds in its final step until the
// register empties.
module bitmap_block_allocator_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [bba_pkg::OVH_W-1:0]  cfg_wr_data,
  bba_req_if.sink                    req,
  bba_rsp_if.source                  rsp
);

  bba_pkg::dp_cmd_t  dp_cmd;
  bba_pkg::dp_stat_t dp_stat;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  bba_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_cmd     (req.cmd),
    .req_bytes   (req.alloc_bytes),
    .req_index   (req.free_start),
    .cmd         (dp_cmd),
    .stat        (dp_stat),
    .res_status  (rsp.status),
    .res_start   (rsp.start_block),
    .res_run     (rsp.run_blocks),
    .res_left    (rsp.free_blocks_left)
  );

endmodule

// ===== rtl/bba_ram.sv =====
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bba_ctrl.sv =====
module bba_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  bba_pkg::dp_stat_t  stat,
  output bba_pkg::dp_cmd_t   cmd
);

  bba_pkg::state_t  state, state_next;
  bba_pkg::status_t res_code, res_code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bba_pkg::S_CLEAR;
      res_code  <= bba_pkg::ST_OK;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      res_code <= res_code_next;
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next    = state;
    res_code_next = res_code;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.res_code  = res_code;
    case (state)
      bba_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) begin
          state_next = bba_pkg::S_IDLE;
        end
      end
      bba_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = bba_pkg::S_CALC;
        end
      end
      bba_pkg::S_CALC: begin
        if (stat.is_free) begin
          state_next = bba_pkg::S_FCHK;
        end else if (stat.zero_size) begin
          res_code_next = bba_pkg::ST_ZERO;
          state_next    = bba_pkg::S_DONE;
        end else if (!stat.need_ok) begin
          res_code_next = bba_pkg::ST_NOSPACE;
          state_next    = bba_pkg::S_DONE;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = bba_pkg::S_SCAN;
        end
      end
      bba_pkg::S_FCHK: begin
        if (stat.free_ok) begin
          cmd.mark_begin = 1'b1;
          state_next     = bba_pkg::S_MARK;
        end else begin
          res_code_next = bba_pkg::ST_BADFREE;
          state_next    = bba_pkg::S_DONE;
        end
      end
      bba_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_hit) begin
          cmd.mark_begin = 1'b1;
          state_next     = bba_pkg::S_MARK;
        end else if (stat.scan_end) begin
          res_code_next = bba_pkg::ST_NOSPACE;
          state_next    = bba_pkg::S_DONE;
        end
      end
      bba_pkg::S_MARK: begin
        cmd.mark_step = 1'b1;
        if (stat.mark_done) begin
          res_code_next = bba_pkg::ST_OK;
          state_next    = bba_pkg::S_DONE;
        end
      end
      bba_pkg::S_DONE: begin
        // hold until the output register is free or being emptied
        if (!out_valid || out_ready) begin
          cmd.res_load = 1'b1;
          state_next   = bba_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bba_pkg::S_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/bba_dp.sv =====
module bba_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [bba_pkg::OVH_W-1:0]    cfg_wr_data,
  input  logic                         req_cmd,
  input  logic [bba_pkg::BYTES_W-1:0]  req_bytes,
  input  logic [bba_pkg::BLK_W-1:0]    req_index,
  input  bba_pkg::dp_cmd_t             cmd,
  output bba_pkg::dp_stat_t            stat,
  output bba_pkg::status_t             res_status,
  output logic [bba_pkg::BLK_W-1:0]    res_start,
  output logic [bba_pkg::CNT_W-1:0]    res_run,
  output logic [bba_pkg::CNT_W-1:0]    res_left
);

  localparam int BLK_W    = bba_pkg::BLK_W;
  localparam int CNT_W    = bba_pkg::CNT_W;
  localparam int CHUNK_W  = bba_pkg::CHUNK_W;
  localparam int CHUNK_SH = bba_pkg::CHUNK_SH;
  localparam int CHUNK_AW = bba_pkg::CHUNK_AW;
  localparam int SUM_W    = bba_pkg::SUM_W;
  localparam int NEED_W   = bba_pkg::NEED_W;

  // configuration and request
  logic [bba_pkg::OVH_W-1:0]   ovh;
  bba_pkg::cmd_t               cmd_r;
  logic [bba_pkg::BYTES_W-1:0] bytes_r;
  logic [BLK_W-1:0]            idx_r;

  // allocator state
  logic [CNT_W-1:0]            free_cnt;
  logic [BLK_W-1:0]            clr_cnt;
  logic [CNT_W-1:0]            len_r;
  logic [BLK_W-1:0]            start_r;

  // scan
  logic [CHUNK_AW:0]           sc_addr;
  logic                        sc_vld;
  logic [CHUNK_AW-1:0]         sc_idx;
  logic [CNT_W-1:0]            run_cnt;
  logic [BLK_W-1:0]            run_start;

  // mark
  logic [CHUNK_AW-1:0]         mk_addr;
  logic [CHUNK_AW-1:0]         mk_last;
  logic                        mk_act;
  logic                        mk_set;
  logic [BLK_W-1:0]            mk_lo;
  logic [CNT_W-1:0]            mk_end;
  logic                        wb_vld;
  logic [CHUNK_AW-1:0]         wb_idx;

  // memories
  logic                        fm_we;
  logic [CHUNK_AW-1:0]         fm_waddr;
  logic [CHUNK_W-1:0]          fm_wdata;
  logic [CHUNK_AW-1:0]         fm_raddr;
  logic [CHUNK_W-1:0]          fm_rdata;
  logic                        rl_we;
  logic [BLK_W-1:0]            rl_waddr;
  logic [CNT_W-1:0]            rl_wdata;
  logic [CNT_W-1:0]            rl_rdata;

  // combinational
  logic                        is_free;
  logic [SUM_W-1:0]            sum;
  logic [NEED_W-1:0]           need;
  logic                        hit;
  logic [BLK_W-1:0]            hit_pos;
  logic [CNT_W-1:0]            len_c;
  logic [BLK_W-1:0]            st_c;
  logic [BLK_W-1:0]            blk_s;
  logic [BLK_W-1:0]            blk_m;
  logic [CHUNK_W-1:0]          mask;
  logic [BLK_W-1:0]            mb_start;
  logic [CNT_W-1:0]            mb_len;
  logic [CNT_W-1:0]            mb_end;

  assign is_free = (cmd_r == bba_pkg::CMD_FREE);
  assign sum     = SUM_W'(bytes_r) + SUM_W'(ovh) + SUM_W'(bba_pkg::BLOCK_BYTES - 1);
  assign need    = sum[SUM_W-1:bba_pkg::BB_SH];

  // first-fit over one chunk, carrying the open run from the chunk before
  always_comb begin
    hit     = 1'b0;
    hit_pos = run_start;
    len_c   = run_cnt;
    st_c    = run_start;
    blk_s   = '0;
    for (int j = 0; j < CHUNK_W; j++) begin
      blk_s = {sc_idx, CHUNK_SH'(j)};
      if (fm_rdata[j]) begin
        len_c = len_c + CNT_W'(1);
        if (!hit && (len_c >= len_r)) begin
          hit     = 1'b1;
          hit_pos = st_c;
        end
      end else begin
        len_c = '0;
        st_c  = blk_s + BLK_W'(1);
      end
    end
  end

  // blocks of the written-back chunk that fall inside the run
  always_comb begin
    blk_m = '0;
    mask  = '0;
    for (int b = 0; b < CHUNK_W; b++) begin
      blk_m   = {wb_idx, CHUNK_SH'(b)};
      mask[b] = (blk_m >= mk_lo) && (CNT_W'(blk_m) <= mk_end);
    end
  end

  assign mb_start = is_free ? idx_r : hit_pos;
  assign mb_len   = is_free ? rl_rdata : len_r;
  assign mb_end   = CNT_W'(mb_start) + mb_len - CNT_W'(1);

  assign stat.clr_done  = cmd.clr_step && (clr_cnt == BLK_W'(bba_pkg::NUM_BLOCKS - 1));
  assign stat.is_free   = is_free;
  assign stat.zero_size = (bytes_r == '0);
  assign stat.need_ok   = need < NEED_W'(free_cnt);
  assign stat.free_ok   = (CNT_W'(idx_r) < CNT_W'(bba_pkg::NUM_BLOCKS)) && (rl_rdata != '0);
  assign stat.scan_hit  = sc_vld && hit;
  assign stat.scan_end  = sc_vld && !hit && (sc_idx == CHUNK_AW'(bba_pkg::NUM_CHUNKS - 1));
  assign stat.mark_done = wb_vld && (wb_idx == mk_last);

  assign fm_we    = cmd.clr_step || (cmd.mark_step && wb_vld);
  assign fm_waddr = cmd.clr_step ? clr_cnt[BLK_W-1:CHUNK_SH] : wb_idx;
  assign fm_wdata = cmd.clr_step ? '1 : (mk_set ? (fm_rdata | mask) : (fm_rdata & ~mask));
  assign fm_raddr = cmd.mark_step ? mk_addr : sc_addr[CHUNK_AW-1:0];

  assign rl_we    = cmd.clr_step || cmd.mark_begin;
  assign rl_waddr = cmd.clr_step ? clr_cnt : mb_start;
  assign rl_wdata = (cmd.clr_step || is_free) ? '0 : len_r;

  bba_ram #(.WIDTH(CHUNK_W), .DEPTH(bba_pkg::NUM_CHUNKS)) u_free_map (
    .clk   (clk),
    .we    (fm_we),
    .waddr (fm_waddr),
    .wdata (fm_wdata),
    .raddr (fm_raddr),
    .rdata (fm_rdata)
  );

  bba_ram #(.WIDTH(CNT_W), .DEPTH(bba_pkg::NUM_BLOCKS)) u_run_len (
    .clk   (clk),
    .we    (rl_we),
    .waddr (rl_waddr),
    .wdata (rl_wdata),
    .raddr (idx_r),
    .rdata (rl_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ovh      <= bba_pkg::OVH_RESET;
      free_cnt <= CNT_W'(bba_pkg::NUM_BLOCKS);
      clr_cnt  <= '0;
      sc_vld   <= 1'b0;
      mk_act   <= 1'b0;
      wb_vld   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        ovh <= cfg_wr_data;
      end
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + BLK_W'(1);
      end

      if (cmd.scan_start) begin
        sc_vld <= 1'b0;
      end else if (cmd.scan_step) begin
        sc_vld <= !sc_addr[CHUNK_AW];
      end

      if (cmd.mark_begin) begin
        mk_act   <= 1'b1;
        wb_vld   <= 1'b0;
        free_cnt <= is_free ? (free_cnt + mb_len) : (free_cnt - mb_len);
      end else if (cmd.mark_step) begin
        wb_vld <= mk_act;
        if (mk_act && (mk_addr == mk_last)) begin
          mk_act <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= bba_pkg::cmd_t'(req_cmd);
      bytes_r <= req_bytes;
      idx_r   <= req_index;
    end

    if (cmd.scan_start) begin
      len_r     <= need[CNT_W-1:0];
      sc_addr   <= '0;
      run_cnt   <= '0;
      run_start <= '0;
    end else if (cmd.scan_step) begin
      if (!sc_addr[CHUNK_AW]) begin
        sc_addr <= sc_addr + (CHUNK_AW + 1)'(1);
        sc_idx  <= sc_addr[CHUNK_AW-1:0];
      end
      if (sc_vld) begin
        run_cnt   <= len_c;
        run_start <= st_c;
      end
    end

    if (cmd.mark_begin) begin
      start_r <= mb_start;
      len_r   <= mb_len;
      mk_set  <= is_free;
      mk_lo   <= mb_start;
      mk_end  <= mb_end;
      mk_addr <= mb_start[BLK_W-1:CHUNK_SH];
      mk_last <= mb_end[BLK_W-1:CHUNK_SH];
    end else if (cmd.mark_step && mk_act) begin
      wb_idx  <= mk_addr;
      mk_addr <= mk_addr + CHUNK_AW'(1);
    end

    if (cmd.res_load) begin
      res_status <= cmd.res_code;
      res_left   <= free_cnt;
      if (cmd.res_code == bba_pkg::ST_OK) begin
        res_start <= start_r;
        res_run   <= len_r;
      end else begin
        res_start <= '0;
        res_run   <= '0;
      end
    end
  end

endmodule

// ===== rtl/bba_checker.sv =====
module bba_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input bba_pkg::status_t           rsp_status,
  input logic [bba_pkg::BLK_W-1:0]  rsp_start_block,
  input logic [bba_pkg::CNT_W-1:0]  rsp_run_blocks,
  input logic [bba_pkg::CNT_W-1:0]  rsp_free_blocks_left
);

  // reset starts the clearing pass: nothing offered, nothing taken
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!rsp_valid && !req_ready))
    else $error("bba: result or ready seen right after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid)
    else $error("bba: result dropped while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_status != bba_pkg::ST_OK)) |->
      ((rsp_run_blocks == '0) && (rsp_start_block == '0)))
    else $error("bba: failed request reports a run");

  a_ok_run: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_status == bba_pkg::ST_OK)) |-> (rsp_run_blocks != '0))
    else $error("bba: granted or freed run is empty");

  a_free_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |->
      (rsp_free_blocks_left <= bba_pkg::CNT_W'(bba_pkg::NUM_BLOCKS)))
    else $error("bba: free count beyond pool size");

endmodule

bind bitmap_block_allocator_unit bba_checker u_bba_checker (
  .clk                  (clk),
  .rst                  (rst),
  .req_valid            (req.valid),
  .req_ready            (req.ready),
  .rsp_valid            (rsp.valid),
  .rsp_ready            (rsp.ready),
  .rsp_status           (rsp.status),
  .rsp_start_block      (rsp.start_block),
  .rsp_run_blocks       (rsp.run_blocks),
  .rsp_free_blocks_left (rsp.free_blocks_left)
);

// ===== tb/sv/bitmap_block_allocator_unit_tb.sv =====
module bitmap_block_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bba_pkg::status_t          status;
    logic [bba_pkg::BLK_W-1:0] start_block;
    logic [bba_pkg::CNT_W-1:0] run_blocks;
    logic [bba_pkg::CNT_W-1:0] blocks_left;
  } alloc_result_t;

  // Mirror of the pool: free map, run records and free count, plus the
  // result words still owed by the block.
  class alloc_scoreboard;
    bit [bba_pkg::NUM_BLOCKS-1:0] free_map;
    int unsigned                  run_len [bba_pkg::NUM_BLOCKS];
    int unsigned                  free_cnt;
    int unsigned                  overhead;
    int                           live_q[$];
    int                           last_freed;
    alloc_result_t                result_q[$];
    int                           errors;

    function new();
      free_map = '1;
      foreach (run_len[i]) run_len[i] = 0;
      free_cnt   = bba_pkg::NUM_BLOCKS;
      overhead   = bba_pkg::OVH_RESET;
      last_freed = 0;
      errors     = 0;
    endfunction

    function int first_fit(int unsigned need);
      int unsigned len;
      len = 0;
      for (int i = 0; i < bba_pkg::NUM_BLOCKS; i++) begin
        if (free_map[i]) begin
          len++;
          if (len >= need) return i + 1 - int'(need);
        end else begin
          len = 0;
        end
      end
      return -1;
    endfunction

    function void note_request(bba_pkg::cmd_t cmd, logic [bba_pkg::BYTES_W-1:0] bytes,
                               logic [bba_pkg::BLK_W-1:0] idx);
      alloc_result_t r;
      int unsigned   need;
      int            pos;
      int            base;
      r.status      = bba_pkg::ST_OK;
      r.start_block = '0;
      r.run_blocks  = '0;
      base          = int'(idx);
      if (cmd == bba_pkg::CMD_ALLOC) begin
        if (bytes == '0) begin
          r.status = bba_pkg::ST_ZERO;
        end else begin
          need = (int'(bytes) + overhead + bba_pkg::BLOCK_BYTES - 1) / bba_pkg::BLOCK_BYTES;
          // the count test comes first, even where a run would fit
          pos = (need < free_cnt) ? first_fit(need) : -1;
          if (pos < 0) begin
            r.status = bba_pkg::ST_NOSPACE;
          end else begin
            for (int i = pos; i < pos + int'(need); i++) free_map[i] = 1'b0;
            run_len[pos] = need;
            free_cnt -= need;
            live_q.push_back(pos);
            r.start_block = bba_pkg::BLK_W'(pos);
            r.run_blocks  = bba_pkg::CNT_W'(need);
          end
        end
      end else if (run_len[base] == 0) begin
        r.status = bba_pkg::ST_BADFREE;
      end else begin
        for (int i = base; i < base + int'(run_len[base]); i++) free_map[i] = 1'b1;
        free_cnt += run_len[base];
        r.start_block = idx;
        r.run_blocks  = bba_pkg::CNT_W'(run_len[base]);
        run_len[base] = 0;
        last_freed    = base;
        for (int k = 0; k < live_q.size(); k++) begin
          if (live_q[k] == base) begin
            live_q.delete(k);
            break;
          end
        end
      end
      r.blocks_left = bba_pkg::CNT_W'(free_cnt);
      result_q.push_back(r);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(bba_pkg::status_t st, logic [bba_pkg::BLK_W-1:0] sblk,
                               logic [bba_pkg::CNT_W-1:0] rblk,
                               logic [bba_pkg::CNT_W-1:0] left);
      alloc_result_t e;
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual status %0d start %0d",
                 $time, st, sblk);
        errors++;
        return;
      end
      e = result_q.pop_front();
      compare_field("status", e.status, st);
      compare_field("start_block", e.start_block, sblk);
      compare_field("run_blocks", e.run_blocks, rblk);
      compare_field("free_blocks_left", e.blocks_left, left);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [bba_pkg::OVH_W-1:0] cfg_wr_data;

  bba_req_if req_bus();
  bba_rsp_if rsp_bus();

  alloc_scoreboard sb = new();
  int sent_count;
  bit fill_mode;

  bitmap_block_allocator_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_bus),
    .rsp         (rsp_bus)
  );

  always #5 clk = ~clk;

  function bit in_calm();
    return sent_count >= 500 && sent_count < 700;
  endfunction

  function logic [bba_pkg::BYTES_W-1:0] bytes_for(int blocks);
    return bba_pkg::BYTES_W'(blocks * bba_pkg::BLOCK_BYTES - int'(bba_pkg::OVH_RESET));
  endfunction

  function logic [bba_pkg::BYTES_W-1:0] random_size();
    int s;
    s = $urandom_range(99);
    if (s < 70) return bba_pkg::BYTES_W'($urandom_range(1024, 1));
    if (s < 88) return bba_pkg::BYTES_W'($urandom_range(8192, 1));
    if (s < 96) return bba_pkg::BYTES_W'($urandom_range(65535, 1));
    return bba_pkg::BYTES_W'($urandom);
  endfunction

  task automatic send_word(bba_pkg::cmd_t c, logic [bba_pkg::BYTES_W-1:0] b,
                           logic [bba_pkg::BLK_W-1:0] i);
    while (!in_calm() && $urandom_range(99) < 37) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid       <= 1'b1;
    req_bus.cmd         <= c;
    req_bus.alloc_bytes <= b;
    req_bus.free_start  <= i;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    sb.note_request(c, b, i);
    sent_count++;
  endtask

  task automatic random_word();
    bba_pkg::cmd_t               c;
    logic [bba_pkg::BYTES_W-1:0] b;
    logic [bba_pkg::BLK_W-1:0]   i;
    int                          r;
    int                          pick;
    if (sb.free_cnt < 48) fill_mode = 1'b0;
    else if (sb.free_cnt > 960) fill_mode = 1'b1;
    else if ($urandom_range(79) == 0) fill_mode = !fill_mode;
    // unused fields still carry random bits
    b    = bba_pkg::BYTES_W'($urandom);
    i    = bba_pkg::BLK_W'($urandom);
    r    = $urandom_range(99);
    pick = (sb.live_q.size() == 0) ? 0 : sb.live_q[$urandom_range(sb.live_q.size() - 1)];
    if (r < (fill_mode ? 70 : 25) || sb.live_q.size() == 0) begin
      c = bba_pkg::CMD_ALLOC;
      b = random_size();
    end else if (r < 88) begin
      c = bba_pkg::CMD_FREE;
      i = bba_pkg::BLK_W'(pick);
    end else begin
      case ($urandom_range(3))
        0: begin
          c = bba_pkg::CMD_ALLOC;
          b = '0;
        end
        1: c = bba_pkg::CMD_FREE;
        2: begin
          c = bba_pkg::CMD_FREE;
          i = bba_pkg::BLK_W'(sb.last_freed);
        end
        default: begin
          // one past a run's start: inside that run unless it is a single block
          c = bba_pkg::CMD_FREE;
          i = bba_pkg::BLK_W'(pick + 1);
        end
      endcase
    end
    send_word(c, b, i);
  endtask

  task automatic drain();
    req_bus.valid <= 1'b0;
    while (sb.result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_overhead(logic [bba_pkg::OVH_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.overhead = v;
  endtask

  // result side: check each word, then decide ready for the next edge
  initial begin
    int hold_cnt;
    bit hold_done;
    hold_cnt  = 0;
    hold_done = 1'b0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_bus.valid && rsp_bus.ready)
        sb.check_result(rsp_bus.status, rsp_bus.start_block, rsp_bus.run_blocks,
                        rsp_bus.free_blocks_left);
      if (!hold_done && sent_count >= 1000) begin
        hold_cnt  = 600;
        hold_done = 1'b1;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp_bus.ready <= 1'b0;
      end else if (in_calm()) begin
        rsp_bus.ready <= 1'b1;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= 37);
      end
    end
  end

  initial begin
    logic [bba_pkg::OVH_W-1:0] ovh_plan [6];
    ovh_plan = '{8'd0, 8'd255, 8'd0, 8'd1, 8'd0, 8'd128};
    ovh_plan[2] = bba_pkg::OVH_W'($urandom);
    ovh_plan[4] = bba_pkg::OVH_W'($urandom);
    sent_count = 0;
    fill_mode  = 1'b1;
    rst                 <= 1'b1;
    cfg_wr_en           <= 1'b0;
    cfg_wr_data         <= '0;
    req_bus.valid       <= 1'b0;
    req_bus.cmd         <= bba_pkg::CMD_ALLOC;
    req_bus.alloc_bytes <= '0;
    req_bus.free_start  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset overhead
    send_word(bba_pkg::CMD_ALLOC, '0, '0);
    send_word(bba_pkg::CMD_FREE, '0, '0);
    send_word(bba_pkg::CMD_FREE, '0, '1);
    send_word(bba_pkg::CMD_ALLOC, '1, '0);
    send_word(bba_pkg::CMD_ALLOC, bytes_for(bba_pkg::NUM_BLOCKS), '0);
    send_word(bba_pkg::CMD_ALLOC, bytes_for(bba_pkg::NUM_BLOCKS - 1), '0);
    send_word(bba_pkg::CMD_ALLOC, 20'd1, '0);
    send_word(bba_pkg::CMD_FREE, '0, '0);
    send_word(bba_pkg::CMD_FREE, '0, '0);
    send_word(bba_pkg::CMD_ALLOC, 20'd1, '0);
    send_word(bba_pkg::CMD_ALLOC, 20'd24, '0);
    send_word(bba_pkg::CMD_ALLOC, 20'd25, '0);
    send_word(bba_pkg::CMD_ALLOC, bytes_for(bba_pkg::NUM_BLOCKS - 5), '0);
    send_word(bba_pkg::CMD_FREE, '0, 10'd0);
    send_word(bba_pkg::CMD_FREE, '0, 10'd2);
    // enough blocks free in total, but no run of three
    send_word(bba_pkg::CMD_ALLOC, bytes_for(3), '0);
    send_word(bba_pkg::CMD_ALLOC, bytes_for(2), '0);
    send_word(bba_pkg::CMD_FREE, '0, 10'd3);
    send_word(bba_pkg::CMD_FREE, '0, 10'd1);
    send_word(bba_pkg::CMD_FREE, '0, 10'd4);
    send_word(bba_pkg::CMD_FREE, '0, 10'd2);
    send_word(bba_pkg::CMD_ALLOC, 20'd1, '1);
    send_word(bba_pkg::CMD_FREE, '1, 10'd0);
    drain();

    foreach (ovh_plan[p]) begin
      write_overhead(ovh_plan[p]);
      repeat (305) random_word();
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.result_q.size() == 0) begin
      $display("bitmap_block_allocator_unit regression: pass");
    end else begin
      $display("bitmap_block_allocator_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("bitmap_block_allocator_unit regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bba_pkg.sv
rtl/bba_if.sv
rtl/bba_ram.sv
rtl/bba_ctrl.sv
rtl/bba_dp.sv
rtl/bitmap_block_allocator_unit.sv
rtl/bba_checker.sv
tb/sv/bitmap_block_allocator_unit_tb.sv
